@@ design/bvf_pkg.sv @@
// ----------------------------------------------------------------------------
// bvf_pkg
// Shared types, register indexes and the charge-level tables of the battery
// voltage filter.
// ----------------------------------------------------------------------------
package bvf_pkg;

    localparam int MV_W       = 16;
    localparam int HALF_W     = 15;
    localparam int LVL_W      = 7;
    localparam int SLACK_W    = 8;
    localparam int JUMP_W     = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int SEG_W      = 4;
    localparam int SPAN_W     = 8;
    localparam int RISE_W     = 4;
    localparam int RECIP_W    = 10;
    localparam int NUM_W      = 12;
    localparam int QUOT_W     = 6;
    localparam int POINT_N    = 16;
    localparam int SEG_N      = 15;

    localparam logic [CFG_IDX_W-1:0] REG_TREND_SLACK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_JUMP_LIMIT  = 2'd1;

    localparam logic [SLACK_W-1:0] TREND_SLACK_RST = 8'd5;
    localparam logic [JUMP_W-1:0]  JUMP_LIMIT_RST  = 10'd20;

    localparam logic [LVL_W-1:0] FULL_LEVEL = 7'd100;
    localparam logic [LVL_W-1:0] EMPTY_LEVEL = 7'd0;

    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_TREND    = 2'd1,
        ST_JUMP     = 2'd2
    } status_t;

    // Classified item handed from the front to the level pipeline
    typedef struct packed {
        logic [MV_W-1:0] base_mv;
        logic            level_upd;
        status_t         status;
    } cls_item_t;

    typedef struct packed {
        logic [MV_W-1:0]  reported_mv;
        logic [LVL_W-1:0] charge_level;
        status_t          sample_status;
    } result_t;

    // Open-circuit voltage points (half battery voltage, mV) and their levels
    localparam logic [12:0] SocVolt [POINT_N] = '{
        13'd2800, 13'd2881, 13'd2965, 13'd3048, 13'd3133, 13'd3219, 13'd3306, 13'd3392,
        13'd3477, 13'd3562, 13'd3646, 13'd3729, 13'd3897, 13'd3981, 13'd4066, 13'd4150
    };

    localparam logic [LVL_W-1:0] SocLevel [POINT_N] = '{
        7'd0, 7'd0, 7'd0, 7'd3, 7'd7, 7'd13, 7'd18, 7'd27,
        7'd36, 7'd46, 7'd53, 7'd62, 7'd73, 7'd85, 7'd93, 7'd100
    };

    // Per segment: voltage span, level rise, floor(2^16 / span)
    localparam logic [SPAN_W-1:0] SegSpan [SEG_N] = '{
        8'd81, 8'd84, 8'd83, 8'd85, 8'd86, 8'd87, 8'd86, 8'd85,
        8'd85, 8'd84, 8'd83, 8'd168, 8'd84, 8'd85, 8'd84
    };

    localparam logic [RISE_W-1:0] SegRise [SEG_N] = '{
        4'd0, 4'd0, 4'd3, 4'd4, 4'd6, 4'd5, 4'd9, 4'd9,
        4'd10, 4'd7, 4'd9, 4'd11, 4'd12, 4'd8, 4'd7
    };

    localparam logic [RECIP_W-1:0] SegRecip [SEG_N] = '{
        10'd809, 10'd780, 10'd789, 10'd771, 10'd762, 10'd753, 10'd762, 10'd771,
        10'd771, 10'd780, 10'd789, 10'd390, 10'd780, 10'd771, 10'd780
    };

endpackage

@@ design/bvf_fifo.sv @@
// ----------------------------------------------------------------------------
// bvf_fifo
// Small register queue with occupancy count; DEPTH is a power of two.
// ----------------------------------------------------------------------------
module bvf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    output logic                       full,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ design/bvf_front.sv @@
// ----------------------------------------------------------------------------
// bvf_front
// Holds the filter registers and state; classifies each sample and updates
// the previous and base voltages in the cycle the item is accepted.
// ----------------------------------------------------------------------------
module bvf_front
    import bvf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  accept,
    input  logic [MV_W-1:0]       sample_mv,
    input  logic                  adapter_present,
    output cls_item_t             item
);

    logic [SLACK_W-1:0] trend_slack_reg;
    logic [JUMP_W-1:0]  jump_limit_reg;
    logic [MV_W-1:0]    previous_mv_reg, previous_mv_next;
    logic [MV_W-1:0]    base_mv_reg, base_mv_next;

    logic               startup;
    logic [MV_W-1:0]    prev_eff;
    logic [MV_W-1:0]    base_eff;
    logic signed [17:0] delta;
    logic signed [17:0] slack_s;
    logic               trend_ok;
    logic [MV_W-1:0]    mag;
    logic               jump;

    // A zeroed state restarts tracking from the current sample
    assign startup  = (previous_mv_reg == '0) || (base_mv_reg == '0);
    assign prev_eff = startup ? sample_mv : previous_mv_reg;
    assign base_eff = startup ? sample_mv : base_mv_reg;

    assign delta    = $signed({2'b00, sample_mv}) - $signed({2'b00, prev_eff});
    assign slack_s  = $signed({10'b0, trend_slack_reg});
    assign trend_ok = adapter_present ? (delta >= -slack_s) : (delta <= slack_s);
    assign mag      = delta[17] ? MV_W'(-delta) : delta[MV_W-1:0];
    assign jump     = (mag > {6'b0, jump_limit_reg});

    always_comb
    begin
        previous_mv_next = prev_eff;
        base_mv_next     = base_eff;
        item.level_upd   = 1'b0;
        item.status      = ST_TREND;
        if (trend_ok)
        begin
            previous_mv_next = sample_mv;
            if (jump)
            begin
                item.status = ST_JUMP;
            end
            else
            begin
                // Wraps at 16 bits
                base_mv_next   = base_eff + delta[MV_W-1:0];
                item.level_upd = 1'b1;
                item.status    = ST_ACCEPTED;
            end
        end
        item.base_mv = base_mv_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trend_slack_reg <= TREND_SLACK_RST;
            jump_limit_reg  <= JUMP_LIMIT_RST;
            previous_mv_reg <= '0;
            base_mv_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_TREND_SLACK: trend_slack_reg <= cfg_wdata[SLACK_W-1:0];
                    REG_JUMP_LIMIT:  jump_limit_reg  <= cfg_wdata[JUMP_W-1:0];
                    default:         ;
                endcase
            end
            if (accept)
            begin
                previous_mv_reg <= previous_mv_next;
                base_mv_reg     <= base_mv_next;
            end
        end
    end

endmodule

@@ design/bvf_back.sv @@
// ----------------------------------------------------------------------------
// bvf_back
// Three-stage level pipeline: segment search and scaled offset, reciprocal
// multiply, remainder correction; keeps the held charge level.
// ----------------------------------------------------------------------------
module bvf_back
    import bvf_pkg::*;
#(
    parameter int OUT_DEPTH = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  cls_item_t                      in_item,
    input  logic                           in_empty,
    output logic                           in_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
    output logic                           out_push,
    output result_t                        out_result
);

    localparam int CNT_W = $clog2(OUT_DEPTH + 1);

    logic [CNT_W+1:0] occupancy;

    logic              a_valid_reg;
    cls_item_t         a_item_reg;
    logic [HALF_W-1:0] a_half;
    logic [SEG_W-1:0]  a_seg;
    logic              a_fixed;
    logic [LVL_W-1:0]  a_fixed_lvl;
    logic [SPAN_W-1:0] a_off;
    logic [NUM_W-1:0]  a_num;

    logic              b_valid_reg;
    cls_item_t         b_item_reg;
    logic              b_fixed_reg;
    logic [LVL_W-1:0]  b_fixed_lvl_reg;
    logic [SEG_W-1:0]  b_seg_reg;
    logic [NUM_W-1:0]  b_num_reg;
    logic [21:0]       b_prod;

    logic              c_valid_reg;
    cls_item_t         c_item_reg;
    logic              c_fixed_reg;
    logic [LVL_W-1:0]  c_fixed_lvl_reg;
    logic [SEG_W-1:0]  c_seg_reg;
    logic [NUM_W-1:0]  c_num_reg;
    logic [QUOT_W-1:0] c_q0_reg;
    logic [13:0]       c_back;
    logic [NUM_W-1:0]  c_rem;
    logic [QUOT_W-1:0] c_quot;
    logic [LVL_W-1:0]  c_sum;
    logic [LVL_W-1:0]  c_calc_lvl;
    logic [LVL_W-1:0]  c_level;

    logic [LVL_W-1:0]  held_level_reg;

    // Issue only when every item in flight has a reserved output slot
    assign occupancy = (CNT_W+2)'(out_count) + (CNT_W+2)'(a_valid_reg)
                     + (CNT_W+2)'(b_valid_reg) + (CNT_W+2)'(c_valid_reg);
    assign in_pop    = !in_empty && (occupancy < (CNT_W+2)'(OUT_DEPTH));

    // Stage A: locate the segment and scale the offset into it
    assign a_half = a_item_reg.base_mv[MV_W-1:1];

    always_comb
    begin
        a_seg = '0;
        for (int k = 1; k < SEG_N; k++)
        begin
            if (a_half >= {2'b00, SocVolt[k]})
            begin
                a_seg = a_seg + 1'b1;
            end
        end
    end

    always_comb
    begin
        a_fixed     = 1'b0;
        a_fixed_lvl = EMPTY_LEVEL;
        if (a_half >= {2'b00, SocVolt[POINT_N-1]})
        begin
            a_fixed     = 1'b1;
            a_fixed_lvl = FULL_LEVEL;
        end
        else if (a_half < {2'b00, SocVolt[0]})
        begin
            a_fixed     = 1'b1;
            a_fixed_lvl = EMPTY_LEVEL;
        end
    end

    assign a_off = SPAN_W'(a_half - {2'b00, SocVolt[a_seg]});
    assign a_num = {8'b0, SegRise[a_seg]} * {4'b0, a_off};

    // Stage B: quotient estimate by reciprocal, low by at most one
    assign b_prod = {10'b0, b_num_reg} * {12'b0, SegRecip[b_seg_reg]};

    // Stage C: correct the estimate, add the segment base level
    assign c_back     = {8'b0, c_q0_reg} * {6'b0, SegSpan[c_seg_reg]};
    assign c_rem      = c_num_reg - c_back[NUM_W-1:0];
    assign c_quot     = (c_rem >= {4'b0, SegSpan[c_seg_reg]}) ? c_q0_reg + 1'b1 : c_q0_reg;
    assign c_sum      = SocLevel[c_seg_reg] + {1'b0, c_quot};
    assign c_calc_lvl = c_fixed_reg ? c_fixed_lvl_reg
                      : ((c_sum > FULL_LEVEL) ? FULL_LEVEL : c_sum);
    // Hold the last level for rejected samples
    assign c_level    = c_item_reg.level_upd ? c_calc_lvl : held_level_reg;

    assign out_push                 = c_valid_reg;
    assign out_result.reported_mv   = c_item_reg.base_mv;
    assign out_result.charge_level  = c_level;
    assign out_result.sample_status = c_item_reg.status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            c_valid_reg    <= 1'b0;
            held_level_reg <= '0;
        end
        else
        begin
            a_valid_reg <= in_pop;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            if (c_valid_reg)
            begin
                held_level_reg <= c_level;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_item_reg      <= in_item;
        b_item_reg      <= a_item_reg;
        b_fixed_reg     <= a_fixed;
        b_fixed_lvl_reg <= a_fixed_lvl;
        b_seg_reg       <= a_seg;
        b_num_reg       <= a_num;
        c_item_reg      <= b_item_reg;
        c_fixed_reg     <= b_fixed_reg;
        c_fixed_lvl_reg <= b_fixed_lvl_reg;
        c_seg_reg       <= b_seg_reg;
        c_num_reg       <= b_num_reg;
        c_q0_reg        <= b_prod[21:16];
    end

endmodule

@@ design/battery_voltage_filter_soc.sv @@
// ----------------------------------------------------------------------------
// battery_voltage_filter_soc
// Battery voltage filter with piecewise-linear state-of-charge estimate.
// ----------------------------------------------------------------------------
// The block takes one voltage sample per clock while full is low and
// returns one result item per sample, in order. The front filters the
// sample against the previous sample and the tracked base voltage in the
// cycle it is accepted, so items may be pushed back to back; full rises
// only when the classified-item queue (MID_DEPTH entries) backs up. The
// charge level is computed behind that queue by a three-stage pipeline
// (stages A, B and C), and the output queue (OUT_DEPTH entries) sustains
// one result per cycle while pop is held high.
module battery_voltage_filter_soc
    import bvf_pkg::*;
#(
    parameter int MID_DEPTH = 4,
    parameter int OUT_DEPTH = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  push,
    output logic                  full,
    input  logic [MV_W-1:0]       sample_mv,
    input  logic                  adapter_present,
    output logic                  empty,
    input  logic                  pop,
    output logic [MV_W-1:0]       reported_mv,
    output logic [LVL_W-1:0]      charge_level,
    output status_t               sample_status
);

    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    logic                 accept;
    cls_item_t            front_item;
    cls_item_t            mid_item;
    logic                 mid_empty;
    logic                 mid_pop;
    logic [OUT_CNT_W-1:0] out_count;
    logic                 out_push;
    result_t              back_result;
    result_t              head_result;

    assign accept = push && !full;

    bvf_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .accept          (accept),
        .sample_mv       (sample_mv),
        .adapter_present (adapter_present),
        .item            (front_item)
    );

    bvf_fifo #(
        .WIDTH ($bits(cls_item_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .wdata (front_item),
        .full  (full),
        .pop   (mid_pop),
        .rdata (mid_item),
        .empty (mid_empty),
        .count ()
    );

    bvf_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_item    (mid_item),
        .in_empty   (mid_empty),
        .in_pop     (mid_pop),
        .out_count  (out_count),
        .out_push   (out_push),
        .out_result (back_result)
    );

    bvf_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (back_result),
        .full  (),
        .pop   (pop),
        .rdata (head_result),
        .empty (empty),
        .count (out_count)
    );

    assign reported_mv   = head_result.reported_mv;
    assign charge_level  = head_result.charge_level;
    assign sample_status = head_result.sample_status;

endmodule
